### hdl/sgm_pkg.sv
`timescale 1ns / 1ps

package sgm_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Field and register widths.
  localparam int PIX_W = 8;
  localparam int CFG_W = 12;

  localparam logic [CFG_W-1:0] RESET_WIDTH = CFG_W'(640);
  localparam logic [CFG_W-1:0] MIN_WIDTH   = CFG_W'(3);
  localparam logic [CFG_W-1:0] MAX_WIDTH_C = CFG_W'(MAX_WIDTH);

  // Gradient arithmetic.
  localparam int SUM_W = 10;  // weighted sum of one row or column of three pixels
  localparam int GRD_W = 11;  // signed gradient
  localparam int SQ_W  = 20;  // square of one gradient
  localparam int ACC_W = 21;  // sum of both squares
  localparam int SC_W  = 23;  // three times that sum

  // Square root unit: 16-bit radicand, one result bit per step.
  localparam int RAD_W      = 16;
  localparam int RT_STEPS   = RAD_W / 2;
  localparam int RT_STEP_W  = $clog2(RT_STEPS);

  localparam logic [SC_W-1:0]  SAT_LIMIT = SC_W'(65025);
  localparam logic [PIX_W-1:0] MAG_MAX   = PIX_W'(255);

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sgm_root_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] root;
  } sgm_root_rsp_t;

endpackage

### hdl/sgm_ram.sv
`timescale 1ns / 1ps

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sgm_sqrt.sv
`timescale 1ns / 1ps

module sgm_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  sgm_pkg::sgm_root_req_t req,
  output sgm_pkg::sgm_root_rsp_t rsp
);
  import sgm_pkg::*;

  logic                 busy;
  logic                 done;
  logic [RT_STEP_W-1:0] step;
  logic [RAD_W-1:0]     rem;
  logic [RAD_W-1:0]     root;
  logic [RAD_W-1:0]     bitv;
  logic [RAD_W:0]       trial;
  logic                 fits;

  // Classic digit-by-digit root: bit walks down through the even powers of two.
  always_comb begin
    bitv  = RAD_W'(1) << {step, 1'b0};
    trial = {1'b0, root} + {1'b0, bitv};
    fits  = {1'b0, rem} >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.radicand;
        root <= '0;
        step <= RT_STEP_W'(RT_STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem  <= rem - trial[RAD_W-1:0];
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root[PIX_W-1:0];

endmodule

### hdl/sobel_gradient_magnitude.sv
`timescale 1ns / 1ps
// A result item passes READ, GRAD, SQX, SQY, SCALE, ROOT and OUT after its pixel is accepted;
// a saturating one skips ROOT. A pixel that completes an interior window holds off the input
// until its result is through the 8-step square root unit and the shared squarer and has left
// for a free output register; any other pixel holds it off only for the line store update.
// Reset (rst, synchronous, active high) clears the counters and the handshakes and sets the
// image width to 640; the line store memory is not cleared and needs no sweep.

module sobel_gradient_magnitude (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration: image width in pixels per row.
  input  logic                      cfg_wr_en,
  input  logic [sgm_pkg::CFG_W-1:0] cfg_wr_data,
  // Pixel input.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] pixel
  input  logic                      s_axis_tuser,   // [0] frame_start
  // Magnitude output.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] magnitude
  output logic                      m_axis_tlast    // row_end
);
  import sgm_pkg::*;

  // The block works on one pixel at a time. IDLE takes the pixel and issues the
  // line store read; READ shifts the window and writes the column back; the
  // remaining states form the magnitude for pixels that close an interior window.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQX,
    S_SQY,
    S_SCALE,
    S_ROOT,
    S_OUT
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   image_width;
  logic [ADDR_W-1:0]  column_count;
  logic [1:0]         rows_seen;

  // Per-item registers.
  logic [PIX_W-1:0]   pix;
  logic [ADDR_W-1:0]  addr;
  logic               want_result;
  logic               row_end;
  logic [PIX_W-1:0]   win [3][3];  // [row][col], row 0 is the top
  logic signed [GRD_W-1:0] gx;
  logic signed [GRD_W-1:0] gy;
  logic [SQ_W-1:0]    sqx;
  logic [ACC_W-1:0]   sq_sum;
  logic [PIX_W-1:0]   mag;

  // Line store: upper byte is the row two above, lower byte the row above.
  logic               ram_we;
  logic [2*PIX_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [2*PIX_W-1:0] ram_rdata;

  sgm_root_req_t      root_req;
  sgm_root_rsp_t      root_rsp;

  // Combinational helpers.
  logic               accept;
  logic [CFG_W-1:0]   width_eff;
  logic [CFG_W-1:0]   width_m1;
  logic [ADDR_W-1:0]  col_eff;
  logic [1:0]         rows_eff;
  logic               last;
  logic [SUM_W-1:0]   sum_right;
  logic [SUM_W-1:0]   sum_left;
  logic [SUM_W-1:0]   sum_bottom;
  logic [SUM_W-1:0]   sum_top;
  logic signed [GRD_W-1:0]   sq_in;
  logic signed [2*GRD_W-1:0] sq_prod;
  logic [SC_W-1:0]    scaled;
  logic               out_free;

  sgm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sgm_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Width out of range is clamped to 3 .. MAX_WIDTH. A pixel at or past the
  // last column ends the row, which also covers a width lowered mid-row.
  always_comb begin
    if (image_width < MIN_WIDTH) begin
      width_eff = MIN_WIDTH;
    end else if (image_width > MAX_WIDTH_C) begin
      width_eff = MAX_WIDTH_C;
    end else begin
      width_eff = image_width;
    end
    width_m1 = width_eff - 1'b1;
    col_eff  = s_axis_tuser ? '0 : column_count;
    rows_eff = s_axis_tuser ? 2'd0 : rows_seen;
    last     = CFG_W'(col_eff) >= width_m1;
  end

  assign ram_raddr = col_eff;
  assign ram_we    = (state == S_READ);
  assign ram_wdata = {ram_rdata[PIX_W-1:0], pix};

  // Sobel kernels: weighted sums of the outer columns (gx) and rows (gy).
  always_comb begin
    sum_right  = SUM_W'(win[0][2]) + {1'b0, win[1][2], 1'b0} + SUM_W'(win[2][2]);
    sum_left   = SUM_W'(win[0][0]) + {1'b0, win[1][0], 1'b0} + SUM_W'(win[2][0]);
    sum_bottom = SUM_W'(win[2][0]) + {1'b0, win[2][1], 1'b0} + SUM_W'(win[2][2]);
    sum_top    = SUM_W'(win[0][0]) + {1'b0, win[0][1], 1'b0} + SUM_W'(win[0][2]);
  end

  // One squarer serves gx and then gy.
  assign sq_in   = (state == S_SQX) ? gx : gy;
  assign sq_prod = sq_in * sq_in;
  assign scaled  = SC_W'(sq_sum) + SC_W'({sq_sum, 1'b0});

  assign root_req.start    = (state == S_SCALE) && (scaled < SAT_LIMIT);
  assign root_req.radicand = scaled[RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= RESET_WIDTH;
      column_count  <= '0;
      rows_seen     <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        image_width <= cfg_wr_data;
      end
      // A new result item is loaded as the old one leaves or once the register is empty.
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pix         <= s_axis_tdata;
            addr        <= col_eff;
            row_end     <= last;
            want_result <= (rows_eff == 2'd2) && (col_eff >= ADDR_W'(2));
            if (last) begin
              column_count <= '0;
              rows_seen    <= (rows_eff == 2'd2) ? rows_eff : rows_eff + 2'd1;
            end else begin
              column_count <= col_eff + 1'b1;
              rows_seen    <= rows_eff;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          for (int r = 0; r < 3; r++) begin
            win[r][0] <= win[r][1];
            win[r][1] <= win[r][2];
          end
          win[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
          win[1][2] <= ram_rdata[PIX_W-1:0];
          win[2][2] <= pix;
          state     <= want_result ? S_GRAD : S_IDLE;
        end
        S_GRAD: begin
          gx    <= $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
          gy    <= $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
          state <= S_SQX;
        end
        S_SQX: begin
          sqx   <= sq_prod[SQ_W-1:0];
          state <= S_SQY;
        end
        S_SQY: begin
          sq_sum <= ACC_W'(sqx) + ACC_W'(sq_prod[SQ_W-1:0]);
          state  <= S_SCALE;
        end
        S_SCALE: begin
          // Large sums saturate; the rest go through the root unit.
          if (scaled >= SAT_LIMIT) begin
            mag   <= MAG_MAX;
            state <= S_OUT;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_rsp.done) begin
            mag   <= root_rsp.root;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tdata  <= mag;
            m_axis_tlast  <= row_end;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
